// ===== src/blmm_pkg.sv =====
// Shared types, widths and constants for the battery level median monitor.
// No dependencies; compiled first.
package blmm_pkg;

  // Window depth default for the top level parameter
  localparam int DEF_WINDOW_DEPTH = 8;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int LEVEL_W  = 7;
  localparam int ICON_W   = 3;
  localparam int COUNT_W  = 8;
  localparam int MINS_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_COUNT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL       = 2'd3;

  // Register reset values
  localparam logic [LEVEL_W-1:0] RST_CRITICAL_LEVEL = 7'd5;
  localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL      = 7'd15;
  localparam logic [COUNT_W-1:0] RST_ALERT_COUNT    = 8'd6;
  localparam logic [MINS_W-1:0]  RST_MIN_FILL       = 6'd3;

  // Sample clamp and run counter ceiling
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd100;
  localparam logic [COUNT_W-1:0]  RUN_MAX    = 8'd255;

  // Icon codes
  localparam logic [ICON_W-1:0] ICON_5   = 3'd0;
  localparam logic [ICON_W-1:0] ICON_15  = 3'd1;
  localparam logic [ICON_W-1:0] ICON_50  = 3'd2;
  localparam logic [ICON_W-1:0] ICON_75  = 3'd3;
  localparam logic [ICON_W-1:0] ICON_100 = 3'd4;

  // Icon hysteresis thresholds
  localparam logic [LEVEL_W-1:0] TH_100_DOWN = 7'd90;
  localparam logic [LEVEL_W-1:0] TH_75_UP    = 7'd93;
  localparam logic [LEVEL_W-1:0] TH_75_DOWN  = 7'd60;
  localparam logic [LEVEL_W-1:0] TH_50_UP    = 7'd63;
  localparam logic [LEVEL_W-1:0] TH_50_DOWN  = 7'd30;
  localparam logic [LEVEL_W-1:0] TH_15_UP    = 7'd33;
  localparam logic [LEVEL_W-1:0] TH_15_DOWN  = 7'd10;
  localparam logic [LEVEL_W-1:0] TH_5_UP     = 7'd13;

endpackage

// ===== src/blmm_in_if.sv =====
// Input channel: one charge sample and the charging flag per transfer.
// Depends on blmm_pkg.
interface blmm_in_if
  import blmm_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] charge_sample;
  logic                charging;

  modport source (output valid, output charge_sample, output charging, input ready);
  modport sink   (input valid, input charge_sample, input charging, output ready);
endinterface

// ===== src/blmm_out_if.sv =====
// Result channel: filtered level, icon code, alert pulses, charging echo.
// Depends on blmm_pkg.
interface blmm_out_if
  import blmm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] filtered_level;
  logic [ICON_W-1:0]  icon_level;
  logic               low_alert;
  logic               empty_alert;
  logic               charging_shown;

  modport source (output valid, output filtered_level, output icon_level,
                  output low_alert, output empty_alert, output charging_shown,
                  input ready);
  modport sink   (input valid, input filtered_level, input icon_level,
                  input low_alert, input empty_alert, input charging_shown,
                  output ready);
endinterface

// ===== src/blmm_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on blmm_pkg.
interface blmm_cfg_if
  import blmm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/blmm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module blmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/battery_level_median_monitor_core.sv =====
// Battery level median monitor. Each input transfer writes one clamped charge
// sample into a circular window held in RAM, then the median of the filled
// entries is found by rank counting: every entry is taken in turn as a
// candidate and compared against all filled entries, one entry per cycle,
// through two copies of the window RAM (one for the candidate, one for the
// scan). An item with n filled entries passes through an n*n compare pass,
// a drain state and a finish state, which holds while the output is full;
// one item is in work at a time. A finished result waits in an
// output register so the next input can be taken meanwhile. The result also
// carries run-based low and critical alerts and a hysteresis icon code.
// Depends on blmm_pkg, the three channel interfaces and blmm_ram.
module battery_level_median_monitor_core
  import blmm_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  blmm_cfg_if.sink    cfg_ch,
  blmm_in_if.sink     in_ch,
  blmm_out_if.source  out_ch
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL_FILL = CW'(WINDOW_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Icon hysteresis step
  function automatic logic [ICON_W-1:0] next_icon(input logic [ICON_W-1:0] icon,
                                                  input logic [LEVEL_W-1:0] v);
    logic [ICON_W-1:0] res;
    res = icon;
    case (icon)
      ICON_100: res = (v < TH_100_DOWN) ? ICON_75 : ICON_100;
      ICON_75:  res = (v >= TH_75_UP) ? ICON_100 : (v < TH_75_DOWN) ? ICON_50 : ICON_75;
      ICON_50:  res = (v >= TH_50_UP) ? ICON_75 : (v < TH_50_DOWN) ? ICON_15 : ICON_50;
      ICON_15:  res = (v >= TH_15_UP) ? ICON_50 : (v < TH_15_DOWN) ? ICON_5 : ICON_15;
      default:  res = (v >= TH_5_UP) ? ICON_15 : ICON_5;
    endcase
    return res;
  endfunction

  // Configuration registers
  logic [LEVEL_W-1:0] critical_level;
  logic [LEVEL_W-1:0] low_level;
  logic [COUNT_W-1:0] alert_count;
  logic [MINS_W-1:0]  min_fill;

  // Control and monitor state
  logic [1:0]         state;
  logic [AW-1:0]      write_slot;
  logic [CW-1:0]      fill_count;
  logic [COUNT_W-1:0] low_run, low_run_next;
  logic [COUNT_W-1:0] empty_run, empty_run_next;
  logic               low_latched, low_latched_next;
  logic               empty_latched, empty_latched_next;
  logic [ICON_W-1:0]  current_icon, current_icon_next;
  logic               charging_q;

  // Scan counters and compare pipeline
  logic [AW-1:0]      cand_idx;
  logic [AW-1:0]      scan_idx;
  logic               p_valid;
  logic               p_first;
  logic               p_last;
  logic [CW-1:0]      lt_cnt;
  logic [CW-1:0]      le_cnt;
  logic [LEVEL_W-1:0] med_lo;
  logic [LEVEL_W-1:0] med_hi;

  // Output register
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic [ICON_W-1:0]  out_icon;
  logic               out_low;
  logic               out_empty;
  logic               out_chg;

  logic               in_fire;
  logic               out_free;
  logic               fin_fire;
  logic [LEVEL_W-1:0] sample;
  logic [LEVEL_W-1:0] cand_data;
  logic [LEVEL_W-1:0] scan_data;
  logic [CW-1:0]      n_m1;
  logic [CW-1:0]      rank_hi;
  logic [CW-1:0]      rank_lo;
  logic [CW-1:0]      lt_tot;
  logic [CW-1:0]      le_tot;
  logic [LEVEL_W:0]   mid_sum;
  logic [LEVEL_W-1:0] level;
  logic [COUNT_W-1:0] need;
  logic               low_fire;
  logic               empty_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid || out_ch.ready;
  assign fin_fire     = (state == S_FIN) && out_free;

  assign sample = (in_ch.charge_sample > FULL_SCALE) ? FULL_SCALE[LEVEL_W-1:0]
                                                     : in_ch.charge_sample[LEVEL_W-1:0];

  // Two copies of the window: candidate port and scan port
  blmm_ram #(.WIDTH(LEVEL_W), .DEPTH(WINDOW_DEPTH)) u_ram_cand (
    .clk   (clk),
    .we    (in_fire),
    .waddr (write_slot),
    .wdata (sample),
    .raddr (cand_idx),
    .rdata (cand_data)
  );

  blmm_ram #(.WIDTH(LEVEL_W), .DEPTH(WINDOW_DEPTH)) u_ram_scan (
    .clk   (clk),
    .we    (in_fire),
    .waddr (write_slot),
    .wdata (sample),
    .raddr (scan_idx),
    .rdata (scan_data)
  );

  // Rank targets: upper middle, and lower middle for an even count
  assign n_m1    = fill_count - CW'(1);
  assign rank_hi = fill_count >> 1;
  assign rank_lo = rank_hi - CW'(1);

  assign lt_tot = (p_first ? '0 : lt_cnt) + CW'(scan_data < cand_data);
  assign le_tot = (p_first ? '0 : le_cnt) + CW'(scan_data <= cand_data);

  // Median from the two middle values
  assign mid_sum = {1'b0, med_lo} + {1'b0, med_hi};
  assign level   = fill_count[0] ? med_hi : mid_sum[LEVEL_W:1];
  assign need    = (alert_count == '0) ? COUNT_W'(1) : alert_count;

  // Run counters, alert latches and icon for the finishing item
  always_comb begin
    low_run_next       = low_run;
    empty_run_next     = empty_run;
    low_latched_next   = low_latched;
    empty_latched_next = empty_latched;
    low_fire           = 1'b0;
    empty_fire         = 1'b0;
    if (charging_q) begin
      low_run_next       = '0;
      empty_run_next     = '0;
      low_latched_next   = 1'b0;
      empty_latched_next = 1'b0;
    end else begin
      if (level <= critical_level) begin
        low_run_next   = '0;
        empty_run_next = (empty_run == RUN_MAX) ? empty_run : empty_run + COUNT_W'(1);
      end else if (level <= low_level) begin
        low_run_next   = (low_run == RUN_MAX) ? low_run : low_run + COUNT_W'(1);
        empty_run_next = '0;
      end else begin
        low_run_next   = '0;
        empty_run_next = '0;
      end
      if (low_run_next >= need && !low_latched) begin
        low_latched_next = 1'b1;
        low_fire         = 1'b1;
      end
      if (empty_run_next >= need && !empty_latched) begin
        empty_latched_next = 1'b1;
        empty_fire         = 1'b1;
      end
    end
    if (7'(fill_count) >= {1'b0, min_fill}) begin
      current_icon_next = next_icon(current_icon, level);
    end else begin
      current_icon_next = current_icon;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      critical_level <= RST_CRITICAL_LEVEL;
      low_level      <= RST_LOW_LEVEL;
      alert_count    <= RST_ALERT_COUNT;
      min_fill       <= RST_MIN_FILL;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_CRITICAL_LEVEL: critical_level <= cfg_ch.data[LEVEL_W-1:0];
        REG_LOW_LEVEL:      low_level      <= cfg_ch.data[LEVEL_W-1:0];
        REG_ALERT_COUNT:    alert_count    <= cfg_ch.data[COUNT_W-1:0];
        REG_MIN_FILL:       min_fill       <= cfg_ch.data[MINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: write, n*n rank compare pass, drain, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      cand_idx   <= '0;
      scan_idx   <= '0;
      p_valid    <= 1'b0;
    end else begin
      p_valid <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + AW'(1);
            if (fill_count != FULL_FILL) begin
              fill_count <= fill_count + CW'(1);
            end
            cand_idx <= '0;
            scan_idx <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (CW'(scan_idx) == n_m1) begin
            scan_idx <= '0;
            if (CW'(cand_idx) == n_m1) begin
              state <= S_WAIT;
            end else begin
              cand_idx <= cand_idx + AW'(1);
            end
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        S_WAIT: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Compare pipeline flags and rank counts
  always_ff @(posedge clk) begin
    p_first <= (scan_idx == '0);
    p_last  <= (CW'(scan_idx) == n_m1);
    if (in_fire) begin
      charging_q <= in_ch.charging;
    end
    if (p_valid) begin
      lt_cnt <= lt_tot;
      le_cnt <= le_tot;
      if (p_last) begin
        if (lt_tot <= rank_hi && le_tot > rank_hi) begin
          med_hi <= cand_data;
        end
        if (lt_tot <= rank_lo && le_tot > rank_lo) begin
          med_lo <= cand_data;
        end
      end
    end
  end

  // Monitor state update
  always_ff @(posedge clk) begin
    if (rst) begin
      low_run       <= '0;
      empty_run     <= '0;
      low_latched   <= 1'b0;
      empty_latched <= 1'b0;
      current_icon  <= ICON_100;
    end else if (fin_fire) begin
      low_run       <= low_run_next;
      empty_run     <= empty_run_next;
      low_latched   <= low_latched_next;
      empty_latched <= empty_latched_next;
      current_icon  <= current_icon_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (fin_fire) begin
      out_level <= level;
      out_icon  <= current_icon_next;
      out_low   <= low_fire;
      out_empty <= empty_fire;
      out_chg   <= charging_q;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.filtered_level = out_level;
  assign out_ch.icon_level     = out_icon;
  assign out_ch.low_alert      = out_low;
  assign out_ch.empty_alert    = out_empty;
  assign out_ch.charging_shown = out_chg;

`ifndef ASSERT_OFF
  // An accepted item always starts a compare pass
  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_SCAN))
    else $error("accepted item did not start the compare pass");

  // Fill count and write slot stay within the window
  a_window_bounds: assert property (@(posedge clk) disable iff (rst)
    (fill_count <= FULL_FILL) && (32'(write_slot) < WINDOW_DEPTH))
    else $error("window fill or write slot out of range");

  // Low and critical runs exclude each other, so both alerts never fire together
  a_alerts_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_low && out_empty))
    else $error("both alerts fired on one result");

  // A charging result never carries an alert
  a_charging_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_chg) |-> !(out_low || out_empty))
    else $error("alert raised while charging");
`endif

endmodule
